[rtl/rmm_pkg.sv]
// ----------------------------------------------------------------------------
// rmm_pkg
// Shared types and constants of the region min/max/mean statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmm_pkg;

	localparam int CFG_W  = 13;
	localparam int PIX_W  = 8;
	localparam int SUM_W  = 32;
	localparam int SW     = 16;
	localparam int AREA_W = 2 * CFG_W;
	localparam int DIV_W  = AREA_W + PIX_W;
	localparam int STEP_W = $clog2(PIX_W + 1);

	localparam logic [PIX_W-1:0] PIX_MAX = '1;

	typedef logic signed [SW-1:0] coord_t;

	typedef enum logic [1:0] {
		ST_MEASURED = 2'd0,
		ST_OUTSIDE  = 2'd1,
		ST_OVERSIZE = 2'd2
	} roi_status_t;

	typedef struct packed {
		logic [CFG_W-1:0] roi_x;
		logic [CFG_W-1:0] roi_y;
		logic [CFG_W-1:0] roi_width;
		logic [CFG_W-1:0] roi_height;
		logic [CFG_W-1:0] image_width;
		logic [CFG_W-1:0] image_height;
	} cfg_t;

	typedef struct packed {
		coord_t      x0;
		coord_t      y0;
		coord_t      cx;
		coord_t      cy;
		coord_t      iw;
		coord_t      ih;
		roi_status_t status;
	} region_t;

	typedef struct packed {
		logic accept;
		logic capture;
		logic load_area;
		logic div_step;
		logic div_first;
		logic load_out;
	} rmm_cmd_t;

	typedef struct packed {
		logic skip_div;
	} rmm_sts_t;

endpackage

`default_nettype wire

[rtl/rmm_region.sv]
// ----------------------------------------------------------------------------
// rmm_region
// Clips and shifts the configured rectangle against the image bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module rmm_region import rmm_pkg::*; #(
	parameter int MAX_DIM = 4096
) (
	input  cfg_t    cfg,
	output region_t region
);

	localparam coord_t ZERO    = coord_t'(0);
	localparam coord_t ONE     = coord_t'(1);
	localparam coord_t DIM_TOP = coord_t'(MAX_DIM);

	function automatic coord_t clamp_dim(input logic [CFG_W-1:0] v);
		coord_t r;
		r = {{(SW-CFG_W){1'b0}}, v};
		if (r < ONE) begin
			r = ONE;
		end else if (r > DIM_TOP) begin
			r = DIM_TOP;
		end
		return r;
	endfunction

	coord_t sx, sy, w, h, iw, ih;
	coord_t x0a, y0a, cxa, cya, x0s, y0s;
	logic   outside;

	always_comb begin
		sx = {{(SW-CFG_W){cfg.roi_x[CFG_W-1]}}, cfg.roi_x};
		sy = {{(SW-CFG_W){cfg.roi_y[CFG_W-1]}}, cfg.roi_y};
		w  = {{(SW-CFG_W){1'b0}}, cfg.roi_width};
		h  = {{(SW-CFG_W){1'b0}}, cfg.roi_height};
		iw = clamp_dim(cfg.image_width);
		ih = clamp_dim(cfg.image_height);

		outside = ((sx + w) < ZERO) || ((sy + h) < ZERO) || (sx > iw) || (sy > ih);

		x0a = (sx < ZERO) ? ZERO : sx;
		cxa = (sx < ZERO) ? (w + sx) : w;
		y0a = (sy < ZERO) ? ZERO : sy;
		cya = (sy < ZERO) ? (h + sy) : h;
		x0s = ((x0a + cxa) >= iw) ? (iw - cxa) : x0a;
		y0s = ((y0a + cya) >= ih) ? (ih - cya) : y0a;

		region.iw = iw;
		region.ih = ih;
		if (outside) begin
			region.x0     = ZERO;
			region.y0     = ZERO;
			region.cx     = ZERO;
			region.cy     = ZERO;
			region.status = ST_OUTSIDE;
		end else begin
			region.x0     = x0s;
			region.y0     = y0s;
			region.cx     = cxa;
			region.cy     = cya;
			region.status = ((x0s < ZERO) || (y0s < ZERO)) ? ST_OVERSIZE : ST_MEASURED;
		end
	end

endmodule

`default_nettype wire

[rtl/rmm_datapath.sv]
// ----------------------------------------------------------------------------
// rmm_datapath
// Raster counters, running statistics, area multiply, restoring divider and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rmm_datapath import rmm_pkg::*; #(
	parameter int MAX_DIM = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic [PIX_W-1:0] pixel,
	input  rmm_cmd_t         cmd,
	output rmm_sts_t         sts,
	output logic [PIX_W-1:0] peak,
	output logic [PIX_W-1:0] floor_value,
	output logic [PIX_W-1:0] average,
	output logic [1:0]       status
);

	localparam int     CW  = $clog2(MAX_DIM);
	localparam coord_t ONE = coord_t'(1);

	region_t region;

	rmm_region #(
		.MAX_DIM(MAX_DIM)
	) u_region (
		.cfg    (cfg),
		.region (region)
	);

	logic [CW-1:0]     col_q, row_q;
	logic [PIX_W-1:0]  run_peak_q, run_floor_q;
	logic [SUM_W-1:0]  run_sum_q;

	logic [PIX_W-1:0]  cap_peak_q, cap_floor_q;
	roi_status_t       cap_status_q;
	logic [CFG_W-1:0]  cap_cx_q, cap_cy_q;
	logic [SUM_W-1:0]  rem_q;
	logic [DIV_W-1:0]  div_q;
	logic [PIX_W-1:0]  quot_q;
	logic              sat_q, area_zero_q;
	logic [PIX_W-1:0]  peak_q, floor_q, avg_q;
	roi_status_t       status_q;

	coord_t            col_s, row_s;
	logic              in_roi, col_wrap, row_wrap;
	logic [SUM_W:0]    sum_ext;
	logic [PIX_W-1:0]  nxt_peak, nxt_floor;
	logic [SUM_W-1:0]  nxt_sum;
	logic [AREA_W-1:0] area_prod;
	logic              div_ge;

	always_comb begin
		col_s = {{(SW-CW){1'b0}}, col_q};
		row_s = {{(SW-CW){1'b0}}, row_q};
		in_roi = (region.status == ST_MEASURED) &&
			(col_s >= region.x0) && (col_s < (region.x0 + region.cx)) &&
			(row_s >= region.y0) && (row_s < (region.y0 + region.cy));
		col_wrap = col_s >= (region.iw - ONE);
		row_wrap = row_s >= (region.ih - ONE);

		sum_ext   = {1'b0, run_sum_q} + {{(SUM_W+1-PIX_W){1'b0}}, pixel};
		nxt_peak  = (in_roi && (pixel > run_peak_q)) ? pixel : run_peak_q;
		nxt_floor = (in_roi && (pixel < run_floor_q)) ? pixel : run_floor_q;
		if (!in_roi) begin
			nxt_sum = run_sum_q;
		end else if (sum_ext[SUM_W]) begin
			nxt_sum = '1;
		end else begin
			nxt_sum = sum_ext[SUM_W-1:0];
		end

		area_prod = AREA_W'(cap_cx_q) * AREA_W'(cap_cy_q);
		div_ge    = {{(DIV_W-SUM_W){1'b0}}, rem_q} >= div_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			run_peak_q  <= '0;
			run_floor_q <= PIX_MAX;
			run_sum_q   <= '0;
		end else if (cmd.capture) begin
			col_q       <= '0;
			row_q       <= '0;
			run_peak_q  <= '0;
			run_floor_q <= PIX_MAX;
			run_sum_q   <= '0;
		end else if (cmd.accept) begin
			run_peak_q  <= nxt_peak;
			run_floor_q <= nxt_floor;
			run_sum_q   <= nxt_sum;
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cap_peak_q   <= nxt_peak;
			cap_floor_q  <= nxt_floor;
			rem_q        <= nxt_sum;
			cap_status_q <= region.status;
			cap_cx_q     <= region.cx[CFG_W-1:0];
			cap_cy_q     <= region.cy[CFG_W-1:0];
		end
		if (cmd.load_area) begin
			div_q       <= {area_prod, {PIX_W{1'b0}}};
			area_zero_q <= area_prod == '0;
			sat_q       <= 1'b0;
			quot_q      <= '0;
		end
		if (cmd.div_step) begin
			div_q <= div_q >> 1;
			if (cmd.div_first) begin
				sat_q <= div_ge;
			end else begin
				if (div_ge) begin
					rem_q <= rem_q - div_q[SUM_W-1:0];
				end
				quot_q <= {quot_q[PIX_W-2:0], div_ge};
			end
		end
		if (cmd.load_out) begin
			status_q <= cap_status_q;
			unique case (cap_status_q)
				ST_MEASURED: begin
					peak_q  <= cap_peak_q;
					floor_q <= cap_floor_q;
					avg_q   <= area_zero_q ? '0 : (sat_q ? PIX_MAX : quot_q);
				end
				ST_OUTSIDE: begin
					peak_q  <= '0;
					floor_q <= '0;
					avg_q   <= '0;
				end
				default: begin
					peak_q  <= '0;
					floor_q <= PIX_MAX;
					avg_q   <= '0;
				end
			endcase
		end
	end

	assign sts.skip_div = area_zero_q || (cap_status_q != ST_MEASURED);
	assign peak         = peak_q;
	assign floor_value  = floor_q;
	assign average      = avg_q;
	assign status       = status_q;

endmodule

`default_nettype wire

[rtl/rmm_ctrl.sv]
// ----------------------------------------------------------------------------
// rmm_ctrl
// Sequencer: pixel intake, area multiply, divide steps and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module rmm_ctrl import rmm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     frame_end,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  rmm_sts_t sts,
	output rmm_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_AREA,
		S_DIVIDE,
		S_FINISH
	} state_t;

	localparam logic [STEP_W-1:0] STEPS = STEP_W'(PIX_W);

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              out_free;

	always_comb begin
		out_free      = !out_valid_q || !out_stall;
		cmd           = '0;
		cmd.accept    = in_valid && (state_q == S_IDLE);
		cmd.capture   = cmd.accept && frame_end;
		cmd.load_area = state_q == S_AREA;
		cmd.div_step  = (state_q == S_DIVIDE) && !sts.skip_div;
		cmd.div_first = cmd.div_step && (step_q == STEPS);
		cmd.load_out  = (state_q == S_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.capture) begin
						state_q <= S_AREA;
					end
				end
				S_AREA: begin
					state_q <= S_DIVIDE;
					step_q  <= STEPS;
				end
				S_DIVIDE: begin
					if (sts.skip_div || (step_q == '0)) begin
						state_q <= S_FINISH;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[rtl/roi_min_max_mean.sv]
// ----------------------------------------------------------------------------
// roi_min_max_mean
// Region-of-interest max, min and mean over a raster-order grayscale frame.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle unless in_stall is high. The word that
// carries frame_end closes the frame: the input then stalls while the clipped
// area is multiplied and the mean is found by a restoring divider that, after
// a saturation check, settles one quotient bit per cycle (skipped for an empty
// or rejected region), and while the result is handed to the output register,
// which waits if a previous result is still held. Pixels of the next frame are
// taken while the result waits to be read. Registers are to be written only
// while no frame is in flight; the block itself does not enforce this.
`default_nettype none

module roi_min_max_mean import rmm_pkg::*; #(
	parameter int MAX_DIM = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [PIX_W-1:0] pixel,
	input  logic             frame_end,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [PIX_W-1:0] peak,
	output logic [PIX_W-1:0] floor_value,
	output logic [PIX_W-1:0] average,
	output logic [1:0]       status
);

	localparam logic [2:0] REG_ROI_X        = 3'd0;
	localparam logic [2:0] REG_ROI_Y        = 3'd1;
	localparam logic [2:0] REG_ROI_WIDTH    = 3'd2;
	localparam logic [2:0] REG_ROI_HEIGHT   = 3'd3;
	localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd4;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd5;

	localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(4096);

	cfg_t     cfg_q;
	rmm_cmd_t cmd;
	rmm_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{roi_x: '0, roi_y: '0, roi_width: '0, roi_height: '0,
				image_width: DIM_RESET, image_height: DIM_RESET};
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ROI_X:        cfg_q.roi_x        <= cfg_data;
				REG_ROI_Y:        cfg_q.roi_y        <= cfg_data;
				REG_ROI_WIDTH:    cfg_q.roi_width    <= cfg_data;
				REG_ROI_HEIGHT:   cfg_q.roi_height   <= cfg_data;
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data;
				REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.frame_end (frame_end),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rmm_datapath #(
		.MAX_DIM(MAX_DIM)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pixel       (pixel),
		.cmd         (cmd),
		.sts         (sts),
		.peak        (peak),
		.floor_value (floor_value),
		.average     (average),
		.status      (status)
	);

	a_busy_after_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && frame_end |=> in_stall)
		else $error("input not stalled after frame end word");

	a_load_into_free_output: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || !out_stall))
		else $error("result loaded over a held output word");

	a_rejected_mean_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_MEASURED) |-> average == '0)
		else $error("nonzero mean for rejected region");

	a_outside_zeros: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OUTSIDE) |-> (peak == '0) && (floor_value == '0))
		else $error("outside region result not cleared");

endmodule

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Region statistics testbench: pixel frames against a frame-level predictor.
// ----------------------------------------------------------------------------
// Directed frames cover the clipping, shifting, outside, oversize, empty-area
// and counter-wrap cases. Random phases then reprogram the region and image
// size, send short frames of random pixels, and check every result word
// field by field while both sides idle in random bursts.
`default_nettype none

module tb;
	import rmm_pkg::*;

	localparam int MAX_DIM       = 4096;
	localparam int NUM_REGS      = 6;
	localparam int TARGET_WORDS  = 950;
	localparam int CALM_WORDS    = 120;
	localparam int SETTLE_CYCLES = 16;
	localparam int CFG_ALL_ONES  = (1 << CFG_W) - 1;
	localparam longint TIME_LIMIT = 64'd3_200_000;

	typedef enum int {
		REG_ROI_X        = 0,
		REG_ROI_Y        = 1,
		REG_ROI_WIDTH    = 2,
		REG_ROI_HEIGHT   = 3,
		REG_IMAGE_WIDTH  = 4,
		REG_IMAGE_HEIGHT = 5
	} reg_index_t;

	typedef struct packed {
		logic [PIX_W-1:0] peak;
		logic [PIX_W-1:0] floor_value;
		logic [PIX_W-1:0] average;
		roi_status_t      status;
	} frame_stats_t;

	class roi_stats_board;
		logic [CFG_W-1:0] regs [NUM_REGS];
		int               col;
		int               row;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] bottom;
		logic [SUM_W-1:0] total;
		frame_stats_t     awaited_stats [$];
		int               errors;

		function new();
			regs[REG_ROI_X]        = '0;
			regs[REG_ROI_Y]        = '0;
			regs[REG_ROI_WIDTH]    = '0;
			regs[REG_ROI_HEIGHT]   = '0;
			regs[REG_IMAGE_WIDTH]  = CFG_W'(MAX_DIM);
			regs[REG_IMAGE_HEIGHT] = CFG_W'(MAX_DIM);
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			col = 0;
			row = 0;
			top = '0;
			bottom = PIX_MAX;
			total = '0;
		endfunction

		function void set_reg(int idx, logic [CFG_W-1:0] v);
			regs[idx] = v;
		endfunction

		function int dim(logic [CFG_W-1:0] v);
			if (v == 0) return 1;
			if (v > MAX_DIM) return MAX_DIM;
			return int'(v);
		endfunction

		function void take_pixel(logic [PIX_W-1:0] pix, logic last);
			int sx, sy, w, h, iw, ih, x0, y0, cx, cy;
			longint area, quot;
			roi_status_t st;
			frame_stats_t res;
			sx = int'($signed(regs[REG_ROI_X]));
			sy = int'($signed(regs[REG_ROI_Y]));
			w  = int'(regs[REG_ROI_WIDTH]);
			h  = int'(regs[REG_ROI_HEIGHT]);
			iw = dim(regs[REG_IMAGE_WIDTH]);
			ih = dim(regs[REG_IMAGE_HEIGHT]);
			x0 = 0;
			y0 = 0;
			cx = 0;
			cy = 0;
			if (sx + w < 0 || sy + h < 0 || sx > iw || sy > ih) begin
				st = ST_OUTSIDE;
			end else begin
				x0 = (sx < 0) ? 0 : sx;
				cx = (sx < 0) ? w + sx : w;
				y0 = (sy < 0) ? 0 : sy;
				cy = (sy < 0) ? h + sy : h;
				if (x0 + cx >= iw) x0 = iw - cx;
				if (y0 + cy >= ih) y0 = ih - cy;
				st = (x0 < 0 || y0 < 0) ? ST_OVERSIZE : ST_MEASURED;
			end
			if (st == ST_MEASURED && col >= x0 && col < x0 + cx &&
			    row >= y0 && row < y0 + cy) begin
				if (pix > top) top = pix;
				if (pix < bottom) bottom = pix;
				if (longint'(total) + pix > 64'hFFFF_FFFF) total = '1;
				else total = total + pix;
			end
			if (col >= iw - 1) begin
				col = 0;
				row = (row >= ih - 1) ? 0 : row + 1;
			end else begin
				col++;
			end
			if (!last) return;
			res.peak = '0;
			res.floor_value = PIX_MAX;
			res.average = '0;
			res.status = st;
			if (st == ST_OUTSIDE) begin
				res.floor_value = '0;
			end else if (st == ST_MEASURED) begin
				res.peak = top;
				res.floor_value = bottom;
				area = longint'(cx) * longint'(cy);
				if (area != 0) begin
					quot = longint'(total) / area;
					res.average = (quot > 255) ? PIX_MAX : PIX_W'(quot);
				end
			end
			awaited_stats.insert(awaited_stats.size(), res);
			clear_frame();
		endfunction

		task report(string what, int got, int want);
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
			errors++;
		endtask

		task match_stats(frame_stats_t got);
			frame_stats_t want;
			if (awaited_stats.size() == 0) begin
				report("result word with nothing pending, status", got.status, 0);
				return;
			end
			want = awaited_stats.pop_front();
			if (got.peak != want.peak) report("peak", got.peak, want.peak);
			if (got.floor_value != want.floor_value)
				report("floor_value", got.floor_value, want.floor_value);
			if (got.average != want.average) report("average", got.average, want.average);
			if (got.status != want.status) report("status", got.status, want.status);
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_write;
	logic [2:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_stall;
	logic [PIX_W-1:0] pixel;
	logic             frame_end;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [PIX_W-1:0] peak;
	logic [PIX_W-1:0] floor_value;
	logic [PIX_W-1:0] average;
	logic [1:0]       status;

	roi_stats_board board = new();
	int  sent = 0;
	int  in_pct = 20;
	int  out_pct = 20;
	int  out_hold = 0;
	bit  quiet = 1'b0;

	roi_min_max_mean #(.MAX_DIM(MAX_DIM)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel(pixel),
		.frame_end(frame_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.peak(peak),
		.floor_value(floor_value),
		.average(average),
		.status(status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#(TIME_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		if (out_hold > 0) out_hold--;
		else if (!quiet && $urandom_range(99) < out_pct) out_hold = $urandom_range(9, 1);
		out_stall <= !quiet && out_hold > 0;
	end

	always @(posedge clk) begin : watch_ports
		frame_stats_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen.peak = peak;
			seen.floor_value = floor_value;
			seen.average = average;
			seen.status = roi_status_t'(status);
			board.match_stats(seen);
		end
		if (arst_n && in_valid && !in_stall) board.take_pixel(pixel, frame_end);
	end

	task automatic send_word(logic [PIX_W-1:0] pix, logic last);
		if (!quiet && $urandom_range(99) < in_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(9, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= pix;
		frame_end <= last;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic send_frame(int len);
		int k;
		logic [PIX_W-1:0] v;
		for (k = 0; k < len; k++) begin
			case ($urandom_range(9))
				0: v = '0;
				1: v = PIX_MAX;
				default: v = PIX_W'($urandom_range(255));
			endcase
			send_word(v, k == len - 1);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (board.awaited_stats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_region(int x, int y, int w, int h, int iw, int ih);
		int vals [NUM_REGS];
		int r;
		vals[REG_ROI_X] = x;
		vals[REG_ROI_Y] = y;
		vals[REG_ROI_WIDTH] = w;
		vals[REG_ROI_HEIGHT] = h;
		vals[REG_IMAGE_WIDTH] = iw;
		vals[REG_IMAGE_HEIGHT] = ih;
		for (r = REG_ROI_X; r <= REG_IMAGE_HEIGHT; r++) begin
			cfg_write <= 1'b1;
			cfg_index <= 3'(r);
			cfg_data <= CFG_W'(vals[r]);
			board.set_reg(r, CFG_W'(vals[r]));
			@(posedge clk);
		end
		cfg_write <= 1'b0;
	endtask

	initial begin : stimulus
		int k, goal, nf, len, iw, ih, iwd, ihd, x, y, w, h;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel = '0;
		frame_end = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty region straight out of reset
		send_word(8'd200, 1'b1);
		settle();
		// negative origin cut at the left and top edges
		program_region(-1, -1, 3, 2, 3, 2);
		for (k = 0; k < 6; k++) send_word((k == 0) ? PIX_MAX : PIX_W'(k * 41), k == 5);
		settle();
		// region past the right and bottom edges, shifted back inside
		program_region(2, 1, 2, 2, 3, 2);
		for (k = 0; k < 6; k++) send_word((k == 4) ? '0 : PIX_MAX - PIX_W'(k), k == 5);
		settle();
		program_region(-MAX_DIM, 0, 0, 1, 3, 2);
		send_word(8'd77, 1'b1);
		settle();
		program_region(0, 0, MAX_DIM, MAX_DIM, 3, 2);
		send_word(8'd9, 1'b1);
		settle();
		// image size zero clamps to one pixel, so counters wrap every word
		program_region(0, 0, 1, 1, 0, 0);
		for (k = 0; k < 3; k++) send_word(PIX_W'(90 - k * 30), k == 2);
		settle();
		// frame ends before the region is complete
		program_region(0, 0, 2, 2, CFG_ALL_ONES, MAX_DIM);
		for (k = 0; k < 3; k++) send_word(PIX_W'(k * 100 + 5), k == 2);
		settle();

		goal = sent + TARGET_WORDS;
		while (sent < goal) begin
			quiet = (sent >= goal - CALM_WORDS);
			case ($urandom_range(2))
				0: in_pct = 0;
				1: in_pct = 10;
				default: in_pct = 35;
			endcase
			case ($urandom_range(2))
				0: out_pct = 0;
				1: out_pct = 10;
				default: out_pct = 35;
			endcase
			iw = $urandom_range(6, 1);
			ih = $urandom_range(5, 1);
			if ($urandom_range(11) == 0) begin
				case ($urandom_range(3))
					0: iw = 0;
					1: iw = MAX_DIM;
					2: iw = CFG_ALL_ONES;
					default: iw = MAX_DIM - 1;
				endcase
			end
			if ($urandom_range(11) == 0) begin
				case ($urandom_range(3))
					0: ih = 0;
					1: ih = MAX_DIM;
					2: ih = CFG_ALL_ONES;
					default: ih = 1;
				endcase
			end
			iwd = board.dim(CFG_W'(iw));
			ihd = board.dim(CFG_W'(ih));
			x = int'($urandom_range(((iwd > 12) ? 12 : iwd) + 5, 0)) - 3;
			y = int'($urandom_range(((ihd > 12) ? 12 : ihd) + 5, 0)) - 3;
			w = $urandom_range(((iwd > 12) ? 12 : iwd) + 3, 0);
			h = $urandom_range(((ihd > 12) ? 12 : ihd) + 3, 0);
			if ($urandom_range(7) == 0) begin
				case ($urandom_range(3))
					0: x = -MAX_DIM;
					1: x = MAX_DIM - 1;
					2: x = -1;
					default: x = 0;
				endcase
			end
			if ($urandom_range(7) == 0) begin
				case ($urandom_range(3))
					0: y = -MAX_DIM;
					1: y = MAX_DIM - 1;
					2: y = -1;
					default: y = 0;
				endcase
			end
			if ($urandom_range(7) == 0) w = ($urandom_range(1) == 0) ? 0 : MAX_DIM;
			if ($urandom_range(7) == 0) h = ($urandom_range(1) == 0) ? 0 : MAX_DIM;
			program_region(x, y, w, h, iw, ih);
			nf = $urandom_range(3, 1);
			for (k = 0; k < nf; k++) begin
				if (iwd <= 12 && ihd <= 12) len = iwd * ihd;
				else len = $urandom_range(40, 1);
				if ($urandom_range(5) == 0) len = $urandom_range(2 * len + 3, 1);
				send_frame(len);
			end
			settle();
		end

		if (board.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
